// ===== src/wbs_pkg.sv =====
package wbs_pkg;

    localparam int WP_DEPTH = 16;
    localparam int WP_AW    = (WP_DEPTH > 1) ? $clog2(WP_DEPTH) : 1;
    localparam int WP_CW    = $clog2(WP_DEPTH + 1);

    localparam logic [30:0] ACCEL_ONE     = 31'd256;
    localparam logic [30:0] RADIUS_RESET  = 31'd128000;
    localparam logic [30:0] T_MAX         = 31'h7FFF_FFFF;

    localparam logic REG_MAX_SPEED     = 1'b0;
    localparam logic REG_ARRIVE_RADIUS = 1'b1;

    typedef enum logic {
        K_PUSH  = 1'b0,
        K_STEER = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [30:0]        accel;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_fb;

    typedef enum logic {
        IU_DIV  = 1'b0,
        IU_SQRT = 1'b1
    } t_iu_op;

    typedef struct packed {
        logic        start;
        t_iu_op      op;
        logic [63:0] num;
        logic [32:0] den;
    } t_iu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_iu_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VSQ,
        S_VSQRT,
        S_TDIV,
        S_NEAR,
        S_OFF,
        S_MAX,
        S_NORM,
        S_QSQ,
        S_LSQRT,
        S_CHK,
        S_CMUL,
        S_CDIV,
        S_RES
    } t_state;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [57:0] mag58(input logic signed [57:0] v);
        return v[57] ? (~v + 58'd1) : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
        logic ovf;
        ovf = (v[58:31] != {28{1'b0}}) && (v[58:31] != {28{1'b1}});
        if (ovf) begin
            return v[58] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/wbs_in_if.sv =====
interface wbs_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] waypoint_x;
    logic signed [31:0] waypoint_y;
    logic signed [31:0] waypoint_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        accel_limit;

    modport source (
        output valid, cmd, waypoint_x, waypoint_y, waypoint_z,
        output pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, accel_limit,
        input  ready
    );
    modport sink (
        input  valid, cmd, waypoint_x, waypoint_y, waypoint_z,
        input  pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, accel_limit,
        output ready
    );
endinterface

// ===== src/wbs_out_if.sv =====
interface wbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] thrust_x;
    logic signed [31:0] thrust_y;
    logic signed [31:0] thrust_z;
    logic [4:0]         waypoints_left;
    logic               push_dropped;

    modport source (
        output valid, thrust_x, thrust_y, thrust_z, waypoints_left, push_dropped,
        input  ready
    );
    modport sink (
        input  valid, thrust_x, thrust_y, thrust_z, waypoints_left, push_dropped,
        output ready
    );
endinterface

// ===== src/waypoint_brake_steering.sv =====
// Waypoint-following steering controller.
// i_item carries one item per valid/ready handshake: cmd 0 appends a waypoint to
// a 16-entry queue, cmd 1 computes a steering command from position, velocity
// and acceleration limit. o_result returns exactly one item per input item, in
// order: thrust vector (zero on push), queued waypoint count and a drop flag.
// The APB port holds max_speed (address 0) and arrive_radius (address 4); write
// them only while the block is idle.
// Input items pass a two-entry queue, so the next item is taken while the
// current one is being worked on. A push result is written to the output
// register when the back end takes the item from that queue. For a steer, the
// shared bit-serial unit runs two 32-step square roots and one or four 64-step
// divisions, the multiplier alternates between a product phase and an
// accumulate phase, and the scale search moves one bit a cycle. Items run one
// at a time through that datapath.
// Reset empties the waypoint queue, sets max_speed to 0 and arrive_radius to
// 500 m. When the receiver stalls, the finished result holds in the output
// register; once the input queue is full, i_item.ready drops.
module waypoint_brake_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wbs_in_if.sink      i_item,
    wbs_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wbs_pkg::*;

    logic [30:0] r_max_speed;
    logic [30:0] r_arrive_radius;
    t_fb         w_fb;
    logic        w_fb_ready;
    t_iu_req     w_iu_req;
    t_iu_rsp     w_iu_rsp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARRIVE_RADIUS) ? {1'b0, r_arrive_radius}
                                                    : {1'b0, r_max_speed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed     <= '0;
            r_arrive_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_ARRIVE_RADIUS) begin
                r_arrive_radius <= pwdata[30:0];
            end else begin
                r_max_speed <= pwdata[30:0];
            end
        end
    end

    wbs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_fb       (w_fb),
        .i_fb_ready (w_fb_ready)
    );

    wbs_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_iu_req),
        .o_rsp   (w_iu_rsp)
    );

    wbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fb            (w_fb),
        .o_fb_ready      (w_fb_ready),
        .i_max_speed     (r_max_speed),
        .i_arrive_radius (r_arrive_radius),
        .o_iu            (w_iu_req),
        .i_iu            (w_iu_rsp),
        .o_result        (o_result)
    );
endmodule

// ===== src/wbs_front.sv =====
module wbs_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wbs_in_if.sink       i_item,
    output wbs_pkg::t_fb o_fb,
    input  logic         i_fb_ready
);
    import wbs_pkg::*;

    t_item      r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_item      w_new;

    assign i_item.ready = (r_cnt != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = o_fb.valid && i_fb_ready;

    always_comb begin
        w_new.kind  = i_item.cmd ? K_STEER : K_PUSH;
        w_new.wx    = i_item.waypoint_x;
        w_new.wy    = i_item.waypoint_y;
        w_new.wz    = i_item.waypoint_z;
        w_new.px    = i_item.pos_x;
        w_new.py    = i_item.pos_y;
        w_new.pz    = i_item.pos_z;
        w_new.vx    = i_item.vel_x;
        w_new.vy    = i_item.vel_y;
        w_new.vz    = i_item.vel_z;
        w_new.accel = (i_item.accel_limit == 31'd0) ? ACCEL_ONE : i_item.accel_limit;
    end

    assign o_fb.valid = (r_cnt != 2'd0);
    assign o_fb.item  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wp] <= w_new;
        end
    end
endmodule

// ===== src/wbs_iter.sv =====
module wbs_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wbs_pkg::t_iu_req i_req,
    output wbs_pkg::t_iu_rsp o_rsp
);
    import wbs_pkg::*;

    logic        r_busy;
    t_iu_op      r_op;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [35:0] r_rem;
    logic [63:0] r_q;
    logic [32:0] r_den;
    logic        r_done;
    logic [35:0] w_sh;
    logic [35:0] w_trial;
    logic        w_ge;

    always_comb begin
        if (r_op == IU_SQRT) begin
            w_sh    = {r_rem[33:0], r_num[63:62]};
            w_trial = {2'b00, r_q[31:0], 2'b01};
        end else begin
            w_sh    = {r_rem[34:0], r_num[63]};
            w_trial = {3'b000, r_den};
        end
        w_ge = (w_sh >= w_trial);
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == IU_SQRT) ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= 36'd0;
            r_q   <= 64'd0;
        end else if (r_busy) begin
            r_num <= (r_op == IU_SQRT) ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_q   <= {r_q[62:0], w_ge};
        end
    end
endmodule

// ===== src/wbs_back.sv =====
module wbs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wbs_pkg::t_fb     i_fb,
    output logic             o_fb_ready,
    input  logic [30:0]      i_max_speed,
    input  logic [30:0]      i_arrive_radius,
    output wbs_pkg::t_iu_req o_iu,
    input  wbs_pkg::t_iu_rsp i_iu,
    wbs_out_if.source        o_result
);
    import wbs_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [31:0] r_mem_x [WP_DEPTH];
    logic signed [31:0] r_mem_y [WP_DEPTH];
    logic signed [31:0] r_mem_z [WP_DEPTH];
    logic [WP_AW-1:0]   r_head;
    logic [WP_CW-1:0]   r_count;

    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_tgt [3];
    logic signed [57:0] r_d   [3];
    logic [30:0]        r_q   [3];
    logic [30:0]        r_a;
    logic [30:0]        r_t;
    logic               r_hasq;
    logic               r_far;
    logic [31:0]        r_vmag;
    logic [31:0]        r_len;
    logic [63:0]        r_acc;
    logic signed [65:0] r_prod;
    logic [56:0]        r_mx;
    logic [5:0]         r_s;
    logic [1:0]         r_k;
    logic               r_ph;

    logic               r_ov;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic signed [31:0] r_tz;
    logic [4:0]         r_left;
    logic               r_drop;

    logic               w_out_free;
    logic               w_take;
    logic               w_is_push;
    logic               w_full;
    logic [WP_CW:0]     w_slot_sum;
    logic [WP_AW-1:0]   w_slot;
    logic [WP_AW-1:0]   w_head_nx;
    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [31:0] w_pos_k;
    logic signed [31:0] w_vel_k;
    logic signed [31:0] w_tgt_k;
    logic signed [57:0] w_d_k;
    logic [32:0]        w_md;
    logic [56:0]        w_m [3];
    logic [30:0]        w_qk;
    logic [56:0]        w_mk;
    logic [30:0]        w_qr;
    logic signed [57:0] w_off;
    logic signed [57:0] w_dnew;
    logic [63:0]        w_lens;
    logic               w_last;
    logic               w_pop_wp;
    logic [57:0]        w_cres;

    assign w_out_free = !r_ov || o_result.ready;
    assign w_is_push  = (i_fb.item.kind == K_PUSH);
    assign w_full     = (r_count == WP_CW'(WP_DEPTH));
    assign w_slot_sum = {1'b0, r_count} + (WP_CW+1)'(r_head);
    assign w_slot     = (w_slot_sum >= (WP_CW+1)'(WP_DEPTH))
                      ? WP_AW'(w_slot_sum - (WP_CW+1)'(WP_DEPTH)) : WP_AW'(w_slot_sum);
    assign w_head_nx  = (r_head == WP_AW'(WP_DEPTH - 1)) ? '0 : r_head + WP_AW'(1);
    assign w_last     = (r_k == 2'd2);

    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_pos_k = r_pos[0]; w_vel_k = r_vel[0]; w_tgt_k = r_tgt[0];
                w_d_k = r_d[0]; w_mk = w_m[0]; w_qr = r_q[0];
            end
            2'd1: begin
                w_pos_k = r_pos[1]; w_vel_k = r_vel[1]; w_tgt_k = r_tgt[1];
                w_d_k = r_d[1]; w_mk = w_m[1]; w_qr = r_q[1];
            end
            2'd2: begin
                w_pos_k = r_pos[2]; w_vel_k = r_vel[2]; w_tgt_k = r_tgt[2];
                w_d_k = r_d[2]; w_mk = w_m[2]; w_qr = r_q[2];
            end
            default: begin
                w_pos_k = '0; w_vel_k = '0; w_tgt_k = '0;
                w_d_k = '0; w_mk = '0; w_qr = '0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i] = 57'(mag58(r_d[i]));
        end
        w_md   = mag33({w_tgt_k[31], w_tgt_k} - {w_pos_k[31], w_pos_k});
        w_qk   = 31'(w_mk >> r_s);
        w_off  = 58'(r_prod >>> 8);
        w_dnew = 58'(w_tgt_k) - 58'(w_pos_k) - w_off;
        w_lens = 64'(r_len) << r_s;
        w_cres = {27'd0, i_iu.res[30:0]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_fb.valid && !w_is_push) begin
                    n_state = S_VSQ;
                end
            end
            S_VSQ: begin
                if (r_ph && w_last) n_state = S_VSQRT;
            end
            S_VSQRT: begin
                if (r_ph && i_iu.done) n_state = S_TDIV;
            end
            S_TDIV: begin
                if (r_ph && i_iu.done) n_state = r_hasq ? S_NEAR : S_OFF;
            end
            S_NEAR: begin
                if (r_ph && r_k == 2'd3) n_state = S_OFF;
            end
            S_OFF: begin
                if (r_ph && w_last) n_state = S_MAX;
            end
            S_MAX: n_state = S_NORM;
            S_NORM: begin
                if (r_mx[56:31] == '0) n_state = S_QSQ;
            end
            S_QSQ: begin
                if (r_ph && w_last) n_state = S_LSQRT;
            end
            S_LSQRT: begin
                if (r_ph && i_iu.done) n_state = S_CHK;
            end
            S_CHK: begin
                n_state = (w_lens > {33'd0, i_max_speed} && r_len != '0) ? S_CMUL : S_RES;
            end
            S_CMUL: n_state = S_CDIV;
            S_CDIV: begin
                if (r_ph && i_iu.done) n_state = w_last ? S_RES : S_CMUL;
            end
            S_RES: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_take   = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_pop_wp = 1'b0;
        o_iu     = '0;
        unique case (r_state)
            S_IDLE: begin
                w_take = i_fb.valid && (!w_is_push || w_out_free);
            end
            S_VSQ: begin
                w_mul_a = {1'b0, mag32(w_vel_k)};
                w_mul_b = {1'b0, mag32(w_vel_k)};
            end
            S_VSQRT: begin
                o_iu.start = !r_ph;
                o_iu.op    = IU_SQRT;
                o_iu.num   = r_acc;
            end
            S_TDIV: begin
                o_iu.start = !r_ph;
                o_iu.op    = IU_DIV;
                o_iu.num   = {24'd0, r_vmag, 8'd0};
                o_iu.den   = {2'b00, r_a};
            end
            S_NEAR: begin
                if (r_k == 2'd3) begin
                    w_mul_a  = {2'b00, i_arrive_radius};
                    w_mul_b  = {2'b00, i_arrive_radius};
                    w_pop_wp = r_ph && !r_far && (r_acc < r_prod[63:0]);
                end else begin
                    w_mul_a = {2'b00, w_md[30:0]};
                    w_mul_b = {2'b00, w_md[30:0]};
                end
            end
            S_OFF: begin
                w_mul_a = {2'b00, r_t};
                w_mul_b = {w_vel_k[31], w_vel_k};
            end
            S_QSQ: begin
                w_mul_a = {2'b00, w_qk};
                w_mul_b = {2'b00, w_qk};
            end
            S_LSQRT: begin
                o_iu.start = !r_ph;
                o_iu.op    = IU_SQRT;
                o_iu.num   = r_acc;
            end
            S_CMUL: begin
                w_mul_a = {2'b00, w_qr};
                w_mul_b = {2'b00, i_max_speed};
            end
            S_CDIV: begin
                o_iu.start = !r_ph;
                o_iu.op    = IU_DIV;
                o_iu.num   = r_prod[63:0];
                o_iu.den   = {1'b0, r_len};
            end
            default: begin
            end
        endcase
    end

    assign o_fb_ready = w_take;

    assign o_result.valid          = r_ov;
    assign o_result.thrust_x       = r_tx;
    assign o_result.thrust_y       = r_ty;
    assign o_result.thrust_z       = r_tz;
    assign o_result.waypoints_left = r_left;
    assign o_result.push_dropped   = r_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_ph    <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (o_result.valid && o_result.ready) begin
                r_ov <= 1'b0;
            end
            if (w_take && w_is_push) begin
                r_ov <= 1'b1;
                if (!w_full) begin
                    r_count <= r_count + WP_CW'(1);
                end
            end
            if (w_pop_wp) begin
                r_head  <= w_head_nx;
                r_count <= r_count - WP_CW'(1);
            end
            if (r_state == S_RES && w_out_free) begin
                r_ov <= 1'b1;
            end
            if (n_state != r_state) begin
                r_ph <= 1'b0;
                if (r_state != S_CMUL) r_k <= 2'd0;
            end else if (r_state == S_CDIV) begin
                if (!r_ph) r_ph <= 1'b1;
            end else if (r_state == S_VSQ || r_state == S_NEAR || r_state == S_OFF
                         || r_state == S_QSQ) begin
                r_ph <= ~r_ph;
                if (r_ph) r_k <= r_k + 2'd1;
            end else if (r_state == S_VSQRT || r_state == S_TDIV || r_state == S_LSQRT) begin
                if (!r_ph) r_ph <= 1'b1;
            end
            if (r_state == S_CDIV && r_ph && i_iu.done && !w_last) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_take && w_is_push && !w_full) begin
            r_mem_x[w_slot] <= i_fb.item.wx;
            r_mem_y[w_slot] <= i_fb.item.wy;
            r_mem_z[w_slot] <= i_fb.item.wz;
        end
        if (w_take && w_is_push) begin
            r_tx   <= '0;
            r_ty   <= '0;
            r_tz   <= '0;
            r_drop <= w_full;
            r_left <= 5'(w_full ? r_count : r_count + WP_CW'(1));
        end
        unique case (r_state)
            S_IDLE: begin
                r_pos[0] <= i_fb.item.px;
                r_pos[1] <= i_fb.item.py;
                r_pos[2] <= i_fb.item.pz;
                r_vel[0] <= i_fb.item.vx;
                r_vel[1] <= i_fb.item.vy;
                r_vel[2] <= i_fb.item.vz;
                r_a      <= i_fb.item.accel;
                r_hasq   <= (r_count != '0);
                r_acc    <= '0;
                r_far    <= 1'b0;
                if (r_count != '0) begin
                    r_tgt[0] <= r_mem_x[r_head];
                    r_tgt[1] <= r_mem_y[r_head];
                    r_tgt[2] <= r_mem_z[r_head];
                end else begin
                    r_tgt[0] <= i_fb.item.px;
                    r_tgt[1] <= i_fb.item.py;
                    r_tgt[2] <= i_fb.item.pz;
                end
            end
            S_VSQ: begin
                if (r_ph) r_acc <= r_acc + r_prod[63:0];
            end
            S_VSQRT: begin
                if (r_ph && i_iu.done) r_vmag <= i_iu.res[31:0];
            end
            S_TDIV: begin
                if (r_ph && i_iu.done) begin
                    r_t   <= (i_iu.res[63:31] != '0) ? T_MAX : i_iu.res[30:0];
                    r_acc <= '0;
                end
            end
            S_NEAR: begin
                if (!r_ph && r_k != 2'd3 && w_md[32:31] != 2'b00) r_far <= 1'b1;
                if (r_ph && r_k != 2'd3) r_acc <= r_acc + r_prod[63:0];
            end
            S_OFF: begin
                if (r_ph) begin
                    unique case (r_k)
                        2'd0:    r_d[0] <= w_dnew;
                        2'd1:    r_d[1] <= w_dnew;
                        default: r_d[2] <= w_dnew;
                    endcase
                end
            end
            S_MAX: begin
                r_s <= '0;
                if (w_m[0] >= w_m[1] && w_m[0] >= w_m[2]) r_mx <= w_m[0];
                else if (w_m[1] >= w_m[2])                r_mx <= w_m[1];
                else                                      r_mx <= w_m[2];
            end
            S_NORM: begin
                r_acc <= '0;
                if (r_mx[56:31] != '0) begin
                    r_mx <= r_mx >> 1;
                    r_s  <= r_s + 6'd1;
                end
            end
            S_QSQ: begin
                if (!r_ph) begin
                    unique case (r_k)
                        2'd0:    r_q[0] <= w_qk;
                        2'd1:    r_q[1] <= w_qk;
                        default: r_q[2] <= w_qk;
                    endcase
                end else begin
                    r_acc <= r_acc + r_prod[63:0];
                end
            end
            S_LSQRT: begin
                if (r_ph && i_iu.done) r_len <= i_iu.res[31:0];
            end
            S_CDIV: begin
                if (r_ph && i_iu.done) begin
                    unique case (r_k)
                        2'd0:    r_d[0] <= w_d_k[57] ? -$signed(w_cres) : $signed(w_cres);
                        2'd1:    r_d[1] <= w_d_k[57] ? -$signed(w_cres) : $signed(w_cres);
                        default: r_d[2] <= w_d_k[57] ? -$signed(w_cres) : $signed(w_cres);
                    endcase
                end
            end
            S_RES: begin
                if (w_out_free) begin
                    r_tx   <= sat32($signed({r_d[0][57], r_d[0]}) - 59'(r_vel[0]));
                    r_ty   <= sat32($signed({r_d[1][57], r_d[1]}) - 59'(r_vel[1]));
                    r_tz   <= sat32($signed({r_d[2][57], r_d[2]}) - 59'(r_vel[2]));
                    r_drop <= 1'b0;
                    r_left <= 5'(r_count);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== tb/tb_waypoint_brake_steering.sv =====
module tb_waypoint_brake_steering;
    timeunit 1ns;
    timeprecision 1ps;

    import wbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IDLE_DRAIN     = 400;
    localparam logic [2:0] ADDR_MAX_SPEED = 3'd0;
    localparam logic [2:0] ADDR_RADIUS    = 3'd4;

    typedef struct {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic [4:0]         left;
        logic               dropped;
    } t_thrust;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wbs_in_if  item_if ();
    wbs_out_if result_if ();

    waypoint_brake_steering dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if.sink),
        .o_result (result_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic signed [63:0] wp_x [WP_DEPTH];
    logic signed [63:0] wp_y [WP_DEPTH];
    logic signed [63:0] wp_z [WP_DEPTH];
    int unsigned        wp_head;
    int unsigned        wp_count;
    logic [63:0]        speed_limit;
    logic [63:0]        radius;

    t_thrust pending_thrust [$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      errors;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_thrust steer_predict(input logic cmd,
            input logic signed [31:0] wx, input logic signed [31:0] wy,
            input logic signed [31:0] wz, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz,
            input logic signed [31:0] vx, input logic signed [31:0] vy,
            input logic signed [31:0] vz, input logic [30:0] acc);
        t_thrust r;
        logic signed [63:0] pos [3];
        logic signed [63:0] vel [3];
        logic signed [63:0] tgt [3];
        logic signed [63:0] d [3];
        logic signed [63:0] off;
        logic signed [127:0] prod;
        logic [63:0] m [3];
        logic [63:0] q [3];
        logic [63:0] a, vmag, t, sum, mx, len, md;
        int unsigned s, h, slot;
        logic near;
        r.tx = 0;
        r.ty = 0;
        r.tz = 0;
        r.dropped = 1'b0;
        if (cmd == K_PUSH) begin
            if (wp_count >= WP_DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                slot = (wp_head + wp_count) % WP_DEPTH;
                wp_x[slot] = 64'(wx);
                wp_y[slot] = 64'(wy);
                wp_z[slot] = 64'(wz);
                wp_count++;
            end
            r.left = wp_count[4:0];
            return r;
        end
        pos[0] = 64'(px); pos[1] = 64'(py); pos[2] = 64'(pz);
        vel[0] = 64'(vx); vel[1] = 64'(vy); vel[2] = 64'(vz);
        a = 64'(acc);
        if (a == 0) a = 256;
        h = wp_head % WP_DEPTH;
        for (int i = 0; i < 3; i++) tgt[i] = pos[i];
        if (wp_count > 0) begin
            tgt[0] = wp_x[h]; tgt[1] = wp_y[h]; tgt[2] = wp_z[h];
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += abs64(vel[i]) * abs64(vel[i]);
        vmag = root64(sum);
        t = (vmag << 8) / a;
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
        if (wp_count > 0) begin
            near = 1'b1;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                md = abs64(tgt[i] - pos[i]);
                if (md >= 64'h8000_0000) near = 1'b0;
                else sum += md * md;
            end
            if (near && sum < radius * radius) begin
                wp_head = (wp_head + 1) % WP_DEPTH;
                wp_count--;
            end
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            prod = $signed({1'b0, t}) * vel[i];
            off = 64'(prod >>> 8);
            d[i] = tgt[i] - (pos[i] + off);
            m[i] = abs64(d[i]);
            if (m[i] > mx) mx = m[i];
        end
        s = 0;
        while ((mx >> s) >= 64'h8000_0000) s++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            q[i] = m[i] >> s;
            sum += q[i] * q[i];
        end
        len = root64(sum);
        if ((len << s) > speed_limit && len != 0) begin
            for (int i = 0; i < 3; i++) begin
                md = q[i] * speed_limit / len;
                d[i] = d[i] < 0 ? -$signed(md) : $signed(md);
            end
        end
        r.tx = clip32(d[0] - vel[0]);
        r.ty = clip32(d[1] - vel[1]);
        r.tz = clip32(d[2] - vel[2]);
        r.left = wp_count[4:0];
        return r;
    endfunction

    task automatic send_item(input logic cmd, input logic signed [31:0] wx,
            input logic signed [31:0] wy, input logic signed [31:0] wz,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz, input logic signed [31:0] vx,
            input logic signed [31:0] vy, input logic signed [31:0] vz,
            input logic [30:0] acc);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.cmd         <= cmd;
        item_if.waypoint_x  <= wx;
        item_if.waypoint_y  <= wy;
        item_if.waypoint_z  <= wz;
        item_if.pos_x       <= px;
        item_if.pos_y       <= py;
        item_if.pos_z       <= pz;
        item_if.vel_x       <= vx;
        item_if.vel_y       <= vy;
        item_if.vel_z       <= vz;
        item_if.accel_limit <= acc;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        pending_thrust.insert(pending_thrust.size(),
                              steer_predict(cmd, wx, wy, wz, px, py, pz,
                                            vx, vy, vz, acc));
    endtask

    task automatic release_bus();
        item_if.valid <= 1'b0;
    endtask

    task automatic push_point(input logic signed [31:0] x,
            input logic signed [31:0] y, input logic signed [31:0] z);
        send_item(K_PUSH, x, y, z, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 31'($urandom));
    endtask

    task automatic steer(input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz, input logic signed [31:0] vx,
            input logic signed [31:0] vy, input logic signed [31:0] vz,
            input logic [30:0] acc);
        send_item(K_STEER, $urandom, $urandom, $urandom, px, py, pz, vx, vy, vz, acc);
    endtask

    task automatic drain();
        release_bus();
        while (pending_thrust.size() != 0) @(posedge i_clk);
        repeat (IDLE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_SPEED) speed_limit = 64'(value[30:0]);
        if (addr == ADDR_RADIUS) radius = 64'(value[30:0]);
    endtask

    task automatic set_limits(input logic [30:0] spd, input logic [30:0] rad);
        drain();
        write_reg(ADDR_MAX_SPEED, {1'b0, spd});
        write_reg(ADDR_RADIUS, {1'b0, rad});
    endtask

    function automatic logic signed [31:0] rand_coord(input int span);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(2 * span)) - span;
        endcase
    endfunction

    task automatic test_directed();
        steer(0, 0, 0, 0, 0, 0, 31'd0);
        steer(32'sh7FFF_FFFF, 32'sh8000_0000, 5, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 31'd0);
        push_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        steer(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1);
        steer(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE, 0, 0, 0,
              31'h7FFF_FFFF);
        for (int i = 0; i < 17; i++) push_point(i * 256, -i * 256, 100);
        steer(1000, 0, 0, 256, -256, 512, 31'd256);
        steer(0, 0, 100, -1, -1, -1, 31'h7FFF_FFFF);
        push_point(7, 7, 7);
        drain();
    endtask

    task automatic test_random(input int n);
        int span;
        logic signed [31:0] bx, by, bz;
        for (int i = 0; i < n; i++) begin
            span = ($urandom_range(3) == 0) ? 32'h3FFF_FFFF : 200000;
            if ($urandom_range(9) < 3) begin
                push_point(rand_coord(span), rand_coord(span), rand_coord(span));
            end else if ($urandom_range(3) == 0 && wp_count > 0) begin
                bx = 32'(wp_x[wp_head] + $signed($urandom_range(60000)) - 30000);
                by = 32'(wp_y[wp_head] + $signed($urandom_range(60000)) - 30000);
                bz = 32'(wp_z[wp_head] + $signed($urandom_range(60000)) - 30000);
                steer(bx, by, bz, $signed($urandom_range(4000)) - 2000,
                      $signed($urandom_range(4000)) - 2000,
                      $signed($urandom_range(4000)) - 2000,
                      31'($urandom_range(2000)));
            end else begin
                steer(rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span),
                      ($urandom_range(4) == 0) ? 31'd0 : 31'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_if.valid = 1'b0;
        item_if.cmd = K_PUSH;
        item_if.waypoint_x = 0;
        item_if.waypoint_y = 0;
        item_if.waypoint_z = 0;
        item_if.pos_x = 0;
        item_if.pos_y = 0;
        item_if.pos_z = 0;
        item_if.vel_x = 0;
        item_if.vel_y = 0;
        item_if.vel_z = 0;
        item_if.accel_limit = 0;
        wp_head = 0;
        wp_count = 0;
        speed_limit = 0;
        radius = 64'(RADIUS_RESET);
        errors = 0;
        send_idle_pct = 27;
        recv_idle_pct = 63;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_limits(31'd0, 31'h7FFF_FFFF);
        test_random(250);
        set_limits(31'h7FFF_FFFF, 31'd0);
        test_directed();
        send_idle_pct = 63;
        recv_idle_pct = 27;
        set_limits(31'd2560, 31'd128000);
        test_random(450);
        set_limits(31'd65536, 31'd4000000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        set_limits(31'($urandom), 31'($urandom));
        test_random(450);
        drain();
        if (errors == 0) begin
            $display("tb_waypoint_brake_steering: PASS");
        end else begin
            $display("tb_waypoint_brake_steering: FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end else begin
            result_if.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_thrust exp_t;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_thrust.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                exp_t = pending_thrust.pop_front();
                if (result_if.thrust_x !== exp_t.tx) begin
                    $error("thrust_x exp %0d got %0d", exp_t.tx, result_if.thrust_x);
                    errors++;
                end
                if (result_if.thrust_y !== exp_t.ty) begin
                    $error("thrust_y exp %0d got %0d", exp_t.ty, result_if.thrust_y);
                    errors++;
                end
                if (result_if.thrust_z !== exp_t.tz) begin
                    $error("thrust_z exp %0d got %0d", exp_t.tz, result_if.thrust_z);
                    errors++;
                end
                if (result_if.waypoints_left !== exp_t.left) begin
                    $error("waypoints_left exp %0d got %0d", exp_t.left,
                           result_if.waypoints_left);
                    errors++;
                end
                if (result_if.push_dropped !== exp_t.dropped) begin
                    $error("push_dropped exp %0d got %0d", exp_t.dropped,
                           result_if.push_dropped);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready)
                || (result_if.valid && result_if.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_waypoint_brake_steering: FAIL");
                $finish;
            end
        end
    end

endmodule
